@@ src/sync_framed_byte_deframer_core_assert.svh @@
// Assertion macros for the byte deframer core.
// Needs a clock named clk and an active-low reset named rst_n in the including module.
`ifndef SYNC_FRAMED_BYTE_DEFRAMER_CORE_ASSERT_SVH
`define SYNC_FRAMED_BYTE_DEFRAMER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SFBD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SFBD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/sfbd_pkg.sv @@
// Shared constants and types for the framed byte deframer.
// No dependencies.
package sfbd_pkg;

    localparam int FRAME_STORE_BYTES = 1024;
    localparam int POS_W             = $clog2(FRAME_STORE_BYTES);
    localparam int BYTE_W            = 8;
    localparam int IDX_W             = 10;
    localparam int SUM_W             = 15;
    localparam int LEN_W             = 16;
    localparam int MIN_FRAME         = 8;

    localparam logic [BYTE_W-1:0] START_FIRST  = 8'hA0;
    localparam logic [BYTE_W-1:0] START_SECOND = 8'hA2;
    localparam logic [BYTE_W-1:0] END_FIRST    = 8'hB0;
    localparam logic [BYTE_W-1:0] END_SECOND   = 8'hB3;

    typedef enum logic [1:0] {
        STAT_GOOD      = 2'd0,
        STAT_SHORT     = 2'd1,
        STAT_LEN_ERR   = 2'd2,
        STAT_CKSUM_ERR = 2'd3
    } frame_status_t;

endpackage

@@ src/sync_framed_byte_deframer_core.sv @@
// Framed byte deframer: start-pair hunt, cut-through byte reporting, end-of-frame checks.
// Depends on sfbd_pkg and sync_framed_byte_deframer_core_assert.svh.
//
// Usage:
//   Input channel (in_valid/in_ready/in_byte) carries one serial byte per word.
//   Output channel (out_valid/out_ready plus result fields) returns exactly one
//   result word per input word, in order: whether the byte was stored and at
//   which index, whether it was dropped (sync hunt, discard after overflow, or
//   the overflow byte itself), and on the byte completing B0 B3 the frame
//   status and payload length.
//   Path: a word accepted into the input register goes through one pass of
//   combinational logic and is loaded into the result register once that
//   register is empty or being drained; out_valid then rises.
//   Throughput: one word per cycle while out_ready stays high; the running
//   checksum, length field and last four bytes are all updated in that single pass.
//   Stall: when out_ready is low with a result waiting, the result register
//   holds, and the input register still takes one more word; in_ready then
//   drops until the result is taken. Nothing is lost or repeated.
//   Reset (rst_n low, asynchronous): both stages empty, frame position,
//   discard mode, running sum, recent bytes and length field cleared.
module sync_framed_byte_deframer_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [sfbd_pkg::BYTE_W-1:0]      in_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             stored,
    output logic [sfbd_pkg::BYTE_W-1:0]      byte_value,
    output logic [sfbd_pkg::IDX_W-1:0]       byte_index,
    output logic                             dropped,
    output logic                             overflow_hit,
    output logic                             frame_end,
    output logic [1:0]                       frame_status,
    output logic [sfbd_pkg::IDX_W-1:0]       payload_length
);
    import sfbd_pkg::*;

    `include "sync_framed_byte_deframer_core_assert.svh"

    // Input stage
    logic              s1_valid_reg, s1_valid_next;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_adv;

    // Frame state
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              disc_reg, disc_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [BYTE_W-1:0] recent_reg [4];
    logic [BYTE_W-1:0] recent_next [4];
    logic [LEN_W-1:0]  dlen_reg, dlen_next;

    // Result register
    logic                out_valid_reg, out_valid_next;
    logic                stored_reg, stored_next;
    logic [BYTE_W-1:0]   value_reg;
    logic [IDX_W-1:0]    index_reg, index_next;
    logic                dropped_reg, dropped_next;
    logic                ovf_reg, ovf_next;
    logic                fend_reg, fend_next;
    frame_status_t       status_reg, status_next;
    logic [IDX_W-1:0]    plen_reg, plen_next;

    // Advance the input stage when the result register is empty or being drained.
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        if (in_valid && in_ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Single pass over one byte: classify, store, run the end-of-frame checks.
    logic [BYTE_W-1:0] b;
    logic [POS_W-1:0]  pos_eff;
    logic [POS_W-1:0]  pos_inc;
    logic              take;
    logic [BYTE_W+1:0] tail;
    logic [SUM_W-1:0]  actual;
    logic [LEN_W-1:0]  declared;
    logic [POS_W-1:0]  plen_full;

    always_comb
    begin
        b            = s1_byte_reg;
        pos_eff      = pos_reg;
        pos_next     = pos_reg;
        disc_next    = disc_reg;
        sum_next     = sum_reg;
        dlen_next    = dlen_reg;
        recent_next  = recent_reg;
        take         = 1'b1;
        dropped_next = 1'b0;
        ovf_next     = 1'b0;
        stored_next  = 1'b0;
        index_next   = '0;
        fend_next    = 1'b0;
        status_next  = STAT_GOOD;
        plen_next    = '0;
        pos_inc      = '0;
        tail         = '0;
        actual       = '0;
        declared     = '0;
        plen_full    = '0;

        priority if (disc_reg)
        begin
            // Drop up to and including the next B3.
            take         = 1'b0;
            dropped_next = 1'b1;
            if (b == END_SECOND)
            begin
                disc_next = 1'b0;
            end
        end
        else if (pos_reg >= POS_W'(FRAME_STORE_BYTES - 1))
        begin
            // Store full: abandon the frame and start discarding.
            take         = 1'b0;
            dropped_next = 1'b1;
            ovf_next     = 1'b1;
            disc_next    = 1'b1;
            pos_next     = '0;
        end
        else if (pos_reg == POS_W'(1) && b != START_SECOND)
        begin
            // Broken start pair: restart, keeping a fresh A0 as index 0.
            pos_eff  = '0;
            pos_next = '0;
            if (b != START_FIRST)
            begin
                take         = 1'b0;
                dropped_next = 1'b1;
            end
        end
        else if (pos_reg == '0 && b != START_FIRST)
        begin
            take         = 1'b0;
            dropped_next = 1'b1;
        end
        else
        begin
            take = 1'b1;
        end

        if (take)
        begin
            stored_next    = 1'b1;
            index_next     = IDX_W'(pos_eff);
            recent_next[3] = recent_reg[2];
            recent_next[2] = recent_reg[1];
            recent_next[1] = recent_reg[0];
            recent_next[0] = b;

            if (pos_eff == '0)
            begin
                sum_next = '0;
            end
            else if (pos_eff == POS_W'(2))
            begin
                dlen_next = {b, dlen_reg[BYTE_W-1:0]};
            end
            else if (pos_eff == POS_W'(3))
            begin
                dlen_next = {dlen_reg[LEN_W-1:BYTE_W], b};
            end
            else if (pos_eff >= POS_W'(4))
            begin
                sum_next = sum_reg + SUM_W'(b);
            end

            pos_inc  = pos_eff + POS_W'(1);
            pos_next = pos_inc;

            if (pos_inc >= POS_W'(2) && recent_next[0] == END_SECOND
                && recent_next[1] == END_FIRST)
            begin
                fend_next = 1'b1;
                pos_next  = '0;
                if (pos_inc < POS_W'(MIN_FRAME))
                begin
                    status_next = STAT_SHORT;
                end
                else
                begin
                    // Take the checksum and end pair back off the running sum.
                    tail = (BYTE_W+2)'(recent_next[0]) + (BYTE_W+2)'(recent_next[1])
                         + (BYTE_W+2)'(recent_next[2]) + (BYTE_W+2)'(recent_next[3]);
                    actual    = sum_next - SUM_W'(tail);
                    declared  = {recent_next[3], recent_next[2]};
                    plen_full = pos_inc - POS_W'(MIN_FRAME);
                    plen_next = IDX_W'(plen_full);
                    if (dlen_next != LEN_W'(plen_full))
                    begin
                        status_next = STAT_LEN_ERR;
                    end
                    else if (declared != LEN_W'(actual))
                    begin
                        status_next = STAT_CKSUM_ERR;
                    end
                    else
                    begin
                        status_next = STAT_GOOD;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            disc_reg      <= 1'b0;
            sum_reg       <= '0;
            dlen_reg      <= '0;
            for (int i = 0; i < 4; i++)
            begin
                recent_reg[i] <= '0;
            end
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_adv)
            begin
                pos_reg    <= pos_next;
                disc_reg   <= disc_next;
                sum_reg    <= sum_next;
                dlen_reg   <= dlen_next;
                recent_reg <= recent_next;
            end
        end
    end

    // Payload registers: hold unless a new word moves in.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= in_byte;
        end
        if (s1_adv)
        begin
            value_reg   <= s1_byte_reg;
            stored_reg  <= stored_next;
            index_reg   <= index_next;
            dropped_reg <= dropped_next;
            ovf_reg     <= ovf_next;
            fend_reg    <= fend_next;
            status_reg  <= status_next;
            plen_reg    <= plen_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign stored         = stored_reg;
    assign byte_value     = value_reg;
    assign byte_index     = index_reg;
    assign dropped        = dropped_reg;
    assign overflow_hit   = ovf_reg;
    assign frame_end      = fend_reg;
    assign frame_status   = status_reg;
    assign payload_length = plen_reg;

    `SFBD_ASSERT_IMP(a_store_xor_drop, out_valid_reg, stored_reg != dropped_reg,
        "byte must be either stored or dropped")
    `SFBD_ASSERT_IMP(a_end_is_stored, out_valid_reg && fend_reg, stored_reg,
        "frame end reported on a byte that was not stored")
    `SFBD_ASSERT_IMP(a_ovf_is_drop, out_valid_reg && ovf_reg, dropped_reg && !fend_reg,
        "overflow byte must be dropped and cannot end a frame")
    `SFBD_ASSERT_IMP(a_discard_pos, disc_reg, pos_reg == '0,
        "frame position must stay zero in discard mode")
    `SFBD_ASSERT_NXT(a_ovf_enters_discard, s1_adv && ovf_next, disc_reg,
        "overflow did not start discard mode")

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for sync_framed_byte_deframer_core: directed byte table, then
// random framed traffic under several idle and stall patterns, every result word checked.
// Depends on sfbd_pkg and the deframer core RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sfbd_pkg::*;

    localparam int CLK_HALF_NS    = 5;
    localparam int RESET_CYCLES   = 12;
    localparam int PHASE_BYTES    = 110;   // with the overflow run, about 1500 bytes in all
    localparam int LONG_HOLD      = 300;   // receiver hold-off that backs the core up
    localparam int DRAIN_CYCLES   = 20;    // slack after the last expected word
    localparam int CYCLE_LIMIT    = 200000;
    localparam int SHOWN_MISMATCH = 10;

    // One result word as the core reports it
    typedef struct packed {
        logic                  stored;
        logic [BYTE_W-1:0]     value;
        logic [IDX_W-1:0]      index;
        logic                  dropped;
        logic                  overflow;
        logic                  fend;
        frame_status_t         status;
        logic [IDX_W-1:0]      plen;
    } byte_report_t;

    // One row of the directed table: input byte, plus a hand-written result where
    // it is obvious; otherwise the deframer prediction is used.
    typedef struct packed {
        logic [BYTE_W-1:0]     data;
        logic                  typed;
        byte_report_t          want;
    } stim_row_t;

    localparam byte_report_t NO_REPORT = '0;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [BYTE_W-1:0]     in_byte = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  stored;
    logic [BYTE_W-1:0]     byte_value;
    logic [IDX_W-1:0]      byte_index;
    logic                  dropped;
    logic                  overflow_hit;
    logic                  frame_end;
    logic [1:0]            frame_status;
    logic [IDX_W-1:0]      payload_length;

    // Deframer state mirrored by the predictor
    int unsigned           frame_pos;
    logic                  in_discard;
    logic [SUM_W-1:0]      payload_sum;
    logic [BYTE_W-1:0]     last_bytes [4];
    logic [LEN_W-1:0]      length_field;

    byte_report_t          pending_reports [$];

    int                    send_idle_pct = 0;
    int                    stall_pct = 0;
    int                    long_hold_req = 0;
    int                    cycle_count = 0;
    int                    bytes_sent = 0;
    int                    words_checked = 0;
    int                    mismatch_count = 0;
    int                    status_tally [4] = '{0, 0, 0, 0};
    int                    drop_tally = 0;
    int                    overflow_tally = 0;
    int                    longest_good = 0;

    stim_row_t directed_rows [26] = '{
        // sync hunt: anything but A0 is dropped
        '{8'h00, 1'b1, '{1'b0, 8'h00, 10'd0, 1'b1, 1'b0, 1'b0, STAT_GOOD, 10'd0}},
        '{8'hFF, 1'b1, '{1'b0, 8'hFF, 10'd0, 1'b1, 1'b0, 1'b0, STAT_GOOD, 10'd0}},
        '{START_FIRST, 1'b1, '{1'b1, 8'hA0, 10'd0, 1'b0, 1'b0, 1'b0, STAT_GOOD, 10'd0}},
        // broken start pair on a plain byte: drop it and hunt again
        '{8'h55, 1'b1, '{1'b0, 8'h55, 10'd0, 1'b1, 1'b0, 1'b0, STAT_GOOD, 10'd0}},
        '{START_FIRST, 1'b1, '{1'b1, 8'hA0, 10'd0, 1'b0, 1'b0, 1'b0, STAT_GOOD, 10'd0}},
        // broken start pair on A0: the A0 restarts the frame at index 0
        '{START_FIRST, 1'b1, '{1'b1, 8'hA0, 10'd0, 1'b0, 1'b0, 1'b0, STAT_GOOD, 10'd0}},
        '{START_SECOND, 1'b1, '{1'b1, 8'hA2, 10'd1, 1'b0, 1'b0, 1'b0, STAT_GOOD, 10'd0}},
        '{END_FIRST, 1'b0, NO_REPORT},
        // four-byte frame ends too short
        '{END_SECOND, 1'b1, '{1'b1, 8'hB3, 10'd3, 1'b0, 1'b0, 1'b1, STAT_SHORT, 10'd0}},
        // one payload byte FF, checksum 0x00FF: good frame
        '{START_FIRST, 1'b0, NO_REPORT},
        '{START_SECOND, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, NO_REPORT},
        '{8'h01, 1'b0, NO_REPORT},
        '{8'hFF, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, NO_REPORT},
        '{8'hFF, 1'b0, NO_REPORT},
        '{END_FIRST, 1'b0, NO_REPORT},
        '{END_SECOND, 1'b1, '{1'b1, 8'hB3, 10'd8, 1'b0, 1'b0, 1'b1, STAT_GOOD, 10'd1}},
        // checksum word with bit 15 set can never match the 15-bit sum
        '{START_FIRST, 1'b0, NO_REPORT},
        '{START_SECOND, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, NO_REPORT},
        '{8'h80, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, NO_REPORT},
        '{END_FIRST, 1'b0, NO_REPORT},
        '{END_SECOND, 1'b1, '{1'b1, 8'hB3, 10'd7, 1'b0, 1'b0, 1'b1, STAT_CKSUM_ERR, 10'd0}}
    };

    sync_framed_byte_deframer_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_byte        (in_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .stored         (stored),
        .byte_value     (byte_value),
        .byte_index     (byte_index),
        .dropped        (dropped),
        .overflow_hit   (overflow_hit),
        .frame_end      (frame_end),
        .frame_status   (frame_status),
        .payload_length (payload_length)
    );

    initial begin
        forever begin
            #(CLK_HALF_NS) clk = ~clk;
        end
    end

    // Advance the mirrored deframer by one byte and return the word it must report.
    function automatic byte_report_t deframe_step(input logic [BYTE_W-1:0] b);
        byte_report_t      r;
        logic              take;
        logic [9:0]        tail;
        logic [SUM_W-1:0]  actual;
        logic [LEN_W-1:0]  declared;
        r = NO_REPORT;
        r.value = b;
        take = 1'b1;
        if (in_discard) begin
            // only a B3 ends the discard after an overflow
            if (b == END_SECOND)
                in_discard = 1'b0;
            r.dropped = 1'b1;
            take = 1'b0;
        end else if (frame_pos >= FRAME_STORE_BYTES - 1) begin
            in_discard = 1'b1;
            frame_pos = 0;
            r.dropped = 1'b1;
            r.overflow = 1'b1;
            take = 1'b0;
        end else if (frame_pos == 1 && b != START_SECOND) begin
            frame_pos = 0;
            if (b != START_FIRST) begin
                r.dropped = 1'b1;
                take = 1'b0;
            end
        end else if (frame_pos == 0 && b != START_FIRST) begin
            r.dropped = 1'b1;
            take = 1'b0;
        end

        if (take) begin
            r.stored = 1'b1;
            r.index = IDX_W'(frame_pos);
            last_bytes[3] = last_bytes[2];
            last_bytes[2] = last_bytes[1];
            last_bytes[1] = last_bytes[0];
            last_bytes[0] = b;
            if (frame_pos == 0)
                payload_sum = '0;
            else if (frame_pos == 2)
                length_field[15:8] = b;
            else if (frame_pos == 3)
                length_field[7:0] = b;
            else if (frame_pos >= 4)
                payload_sum = payload_sum + b;
            frame_pos = frame_pos + 1;

            if (frame_pos >= 2 && last_bytes[0] == END_SECOND && last_bytes[1] == END_FIRST) begin
                r.fend = 1'b1;
                if (frame_pos < MIN_FRAME) begin
                    r.status = STAT_SHORT;
                end else begin
                    // take the checksum word and end pair back out of the running sum
                    tail = {2'b00, last_bytes[0]} + last_bytes[1] + last_bytes[2] + last_bytes[3];
                    actual = payload_sum - tail;
                    declared = {last_bytes[3], last_bytes[2]};
                    r.plen = IDX_W'(frame_pos - MIN_FRAME);
                    if (length_field != frame_pos - MIN_FRAME)
                        r.status = STAT_LEN_ERR;
                    else if (declared != {1'b0, actual})
                        r.status = STAT_CKSUM_ERR;
                end
                frame_pos = 0;
            end
        end
        return r;
    endfunction

    function automatic string report_text(input byte_report_t r);
        return $sformatf("st=%0b val=%h idx=%0d drop=%0b ovf=%0b end=%0b stat=%0d plen=%0d",
                         r.stored, r.value, r.index, r.dropped, r.overflow, r.fend,
                         r.status, r.plen);
    endfunction

    // Offer one byte, with a random gap before it, and hold it until the core takes it.
    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic typed,
                             input byte_report_t want);
        byte_report_t predicted;
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do @(posedge clk); while (!in_ready);
        predicted = deframe_step(b);
        pending_reports.push_back(typed ? want : predicted);
        bytes_sent++;
    endtask

    // Append a byte inside a frame body, never forming an early end pair.
    function automatic void add_body_byte(ref logic [BYTE_W-1:0] q [$],
                                          input logic [BYTE_W-1:0] b);
        if (q.size() != 0 && q[$] == END_FIRST && b == END_SECOND)
            b = ~b;
        q.push_back(b);
    endfunction

    function automatic void build_frame(ref logic [BYTE_W-1:0] q [$], input int n,
                                        input logic bad_len, input logic bad_ck);
        logic [SUM_W-1:0]  ck_sum;
        logic [LEN_W-1:0]  len_word;
        logic [LEN_W-1:0]  ck_word;
        len_word = LEN_W'(n);
        if (bad_len)
            len_word = len_word ^ (LEN_W'(1) << $urandom_range(15));
        q.push_back(START_FIRST);
        q.push_back(START_SECOND);
        q.push_back(len_word[15:8]);
        q.push_back(len_word[7:0]);
        ck_sum = '0;
        repeat (n) begin
            add_body_byte(q, BYTE_W'($urandom_range(255)));
            ck_sum = ck_sum + q[$];
        end
        ck_word = {1'b0, ck_sum};
        if (bad_ck) begin
            if ($urandom_range(1) == 0)
                ck_word = ck_word | 16'h8000;
            else
                ck_word = ck_word ^ (LEN_W'(1) << $urandom_range(14));
        end
        q.push_back(ck_word[15:8]);
        q.push_back(ck_word[7:0]);
        q.push_back(END_FIRST);
        q.push_back(END_SECOND);
    endfunction

    task automatic send_random_frame();
        logic [BYTE_W-1:0] burst [$];
        int                pick;
        int                n;
        pick = $urandom_range(99);
        // mostly short payloads, now and then a longer one
        n = ($urandom_range(9) == 0) ? $urandom_range(120) : $urandom_range(12);
        if (pick < 45) begin
            build_frame(burst, n, 1'b0, 1'b0);
        end else if (pick < 55) begin
            // length error, sometimes with a bad checksum too to test the priority
            build_frame(burst, n, 1'b1, 1'($urandom_range(1)));
        end else if (pick < 65) begin
            build_frame(burst, n, 1'b0, 1'b1);
        end else if (pick < 75) begin
            burst = {START_FIRST, START_SECOND};
            repeat ($urandom_range(3)) burst.push_back(BYTE_W'($urandom_range(255)));
            burst.push_back(END_FIRST);
            burst.push_back(END_SECOND);
        end else if (pick < 83) begin
            burst = {START_FIRST, BYTE_W'($urandom_range(255))};
        end else begin
            repeat ($urandom_range(1, 8)) burst.push_back(BYTE_W'($urandom_range(255)));
        end
        foreach (burst[i]) push_byte(burst[i], 1'b0, NO_REPORT);
    endtask

    // Fill the store to the last index, overflow it, discard, then recover.
    task automatic send_overflow_run();
        logic [BYTE_W-1:0] burst [$];
        logic [BYTE_W-1:0] b;
        burst = {START_FIRST, START_SECOND};
        while (burst.size() < FRAME_STORE_BYTES - 1)
            add_body_byte(burst, BYTE_W'($urandom_range(255)));
        // a B3 that hits the full store starts the discard rather than ending it
        burst.push_back(END_SECOND);
        // a start pair and B0 inside the discard must be dropped too
        burst.push_back(START_FIRST);
        burst.push_back(START_SECOND);
        burst.push_back(END_FIRST);
        repeat (16) begin
            b = BYTE_W'($urandom_range(255));
            burst.push_back((b == END_SECOND) ? 8'h00 : b);
        end
        burst.push_back(END_SECOND);
        build_frame(burst, 3, 1'b0, 1'b0);
        foreach (burst[i]) push_byte(burst[i], 1'b0, NO_REPORT);
    endtask

    // Change idle pattern with the input lowered; settings move at the falling edge.
    task automatic set_traffic(input int send_pct, input int recv_pct, input int hold);
        in_valid <= 1'b0;
        @(negedge clk);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
        long_hold_req = hold;
        @(posedge clk);
    endtask

    function automatic void check_word();
        byte_report_t got;
        byte_report_t want;
        got.stored   = stored;
        got.value    = byte_value;
        got.index    = byte_index;
        got.dropped  = dropped;
        got.overflow = overflow_hit;
        got.fend     = frame_end;
        got.status   = frame_status_t'(frame_status);
        got.plen     = payload_length;
        if (pending_reports.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= SHOWN_MISMATCH)
                $display("cycle %0d: result word with none expected: %s",
                         cycle_count, report_text(got));
            return;
        end
        want = pending_reports.pop_front();
        words_checked++;
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= SHOWN_MISMATCH) begin
                $display("cycle %0d: word %0d mismatch", cycle_count, words_checked);
                $display("  expected %s", report_text(want));
                $display("  actual   %s", report_text(got));
            end
        end else begin
            if (got.fend)
                status_tally[got.status]++;
            if (got.fend && got.status == STAT_GOOD && got.plen > longest_good)
                longest_good = got.plen;
            if (got.dropped)
                drop_tally++;
            if (got.overflow)
                overflow_tally++;
        end
    endfunction

    // Result side: check each word taken, then pick the next ready level.
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (out_valid && out_ready)
                check_word();
            if (long_hold_req > 0) begin
                hold_left = long_hold_req;
                long_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d words still expected",
                 cycle_count, pending_reports.size());
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        int phase_end;
        frame_pos    = 0;
        in_discard   = 1'b0;
        payload_sum  = '0;
        last_bytes   = '{default: '0};
        length_field = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            push_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].want);

        // Phase 0: no idling, long receiver hold-off to back the core up, then a
        // store overflow
        set_traffic(0, 0, LONG_HOLD);
        send_overflow_run();
        phase_end = bytes_sent + PHASE_BYTES;
        while (bytes_sent < phase_end) send_random_frame();

        set_traffic(79, 0, 0);
        phase_end = bytes_sent + PHASE_BYTES;
        while (bytes_sent < phase_end) send_random_frame();

        set_traffic(0, 79, 0);
        phase_end = bytes_sent + PHASE_BYTES;
        while (bytes_sent < phase_end) send_random_frame();

        set_traffic(30, 30, 0);
        phase_end = bytes_sent + PHASE_BYTES;
        while (bytes_sent < phase_end) send_random_frame();

        in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes, checked %0d words: %0d good, %0d short, %0d length err, "
                 , bytes_sent, words_checked, status_tally[STAT_GOOD],
                 status_tally[STAT_SHORT], status_tally[STAT_LEN_ERR]);
        $display("%0d checksum err frames, %0d dropped bytes, %0d overflows, longest payload %0d",
                 status_tally[STAT_CKSUM_ERR], drop_tally, overflow_tally, longest_good);
        if (mismatch_count == 0 && pending_reports.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
